>>> design/lnss_pkg.sv
package lnss_pkg;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_NIBBLE  = 2'd1,
        OP_SET_BIT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_SELECT_POS  = 2'd0,
        REG_STROBE_POS  = 2'd1,
        REG_PULSE_WAIT  = 2'd2,
        REG_SETTLE_WAIT = 2'd3
    } reg_index_t;

    localparam int IMAGE_W = 8;
    localparam int HOLD_W  = 10;
    localparam int POS_W   = 4;

    localparam logic [IMAGE_W-1:0] LOW_NIBBLE_MASK  = 8'h0F;
    localparam logic [IMAGE_W-1:0] HIGH_NIBBLE_MASK = 8'hF0;

    localparam logic [1:0]        SELECT_POS_RESET  = 2'd2;
    localparam logic [1:0]        STROBE_POS_RESET  = 2'd3;
    localparam logic [HOLD_W-1:0] PULSE_WAIT_RESET  = 10'd1;
    localparam logic [HOLD_W-1:0] SETTLE_WAIT_RESET = 10'd100;
    localparam logic [HOLD_W-1:0] NO_WAIT           = 10'd0;

    // step positions of a byte send: select, high nibble (4 steps), low nibble (4 steps)
    localparam logic [POS_W-1:0] SELECT_POS_STEP  = 4'd0;
    localparam logic [POS_W-1:0] HIGH_NIBBLE_STEP = 4'd1;
    localparam logic [POS_W-1:0] LOW_NIBBLE_STEP  = 4'd5;
    localparam logic [POS_W-1:0] LAST_STEP        = 4'd8;

    localparam logic [1:0] PHASE_NIBBLE      = 2'd0;
    localparam logic [1:0] PHASE_STROBE_LOW  = 2'd1;
    localparam logic [1:0] PHASE_STROBE_HIGH = 2'd2;
    localparam logic [1:0] PHASE_SETTLE      = 2'd3;

    typedef struct packed {
        logic [1:0]        select_pos;
        logic [1:0]        strobe_pos;
        logic [HOLD_W-1:0] pulse_wait;
        logic [HOLD_W-1:0] settle_wait;
    } cfg_t;

    typedef struct packed {
        op_t              kind;
        logic [POS_W-1:0] start_step;
        logic [7:0]       data;
        logic             select_level;
        logic [2:0]       bit_index;
        logic             bit_level;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic             busy;
        logic [POS_W-1:0] step;
    } back_status_t;

    function automatic logic [IMAGE_W-1:0] put_bit(
        input logic [IMAGE_W-1:0] image,
        input logic [2:0]         pos,
        input logic               level
    );
        logic [IMAGE_W-1:0] result;
        result      = image;
        result[pos] = level;
        return result;
    endfunction

endpackage

>>> design/lcd_nibble_shift_sequencer.sv
// An accepted request passes the queue and the command register, and its first image is
// then registered onto m_*. Throughput: one image per cycle unless m_ready stalls it;
// a byte send gives 9 images, a nibble 4, a bit set 1, from the single image register.
// The request queue lets the next request be accepted while images are still going out.
// Reset (aresetn low, synchronous): queue emptied, image cleared to zero, registers
// back to select bit 2, strobe bit 3, pulse wait 1 us, settle wait 100 us.
module lcd_nibble_shift_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_data_byte,
    input  logic       s_select_level,
    input  logic [2:0] s_bit_index,
    input  logic       s_bit_level,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_latched_image,
    output logic [9:0] m_hold_us,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);
    import lnss_pkg::*;

    cfg_t          cfg_reg, cfg_next;
    queue_status_t q_status;
    back_status_t  back_status;
    cmd_t          push_cmd;
    cmd_t          head_cmd;
    logic          q_push;
    logic          q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_SELECT_POS:  cfg_next.select_pos  = cfg_data[1:0];
                REG_STROBE_POS:  cfg_next.strobe_pos  = cfg_data[1:0];
                REG_PULSE_WAIT:  cfg_next.pulse_wait  = cfg_data;
                REG_SETTLE_WAIT: cfg_next.settle_wait = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.select_pos  <= SELECT_POS_RESET;
            cfg_reg.strobe_pos  <= STROBE_POS_RESET;
            cfg_reg.pulse_wait  <= PULSE_WAIT_RESET;
            cfg_reg.settle_wait <= SETTLE_WAIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lnss_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_data_byte    (s_data_byte),
        .s_select_level (s_select_level),
        .s_bit_index    (s_bit_index),
        .s_bit_level    (s_bit_level),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_push_cmd     (push_cmd)
    );

    lnss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    lnss_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_status        (q_status),
        .head_cmd        (head_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_latched_image (m_latched_image),
        .m_hold_us       (m_hold_us),
        .m_last          (m_last),
        .status          (back_status)
    );

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("request popped from empty queue");

    a_idle_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (!back_status.busy && !q_status.empty) |=> back_status.busy)
        else $error("sequencer idle with a request waiting");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.busy |-> (back_status.step <= LAST_STEP))
        else $error("sequencer step out of range");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last && q_status.empty && !back_status.busy)
            |=> !m_valid)
        else $error("image shown after final image with nothing pending");

endmodule

>>> design/lnss_front.sv
module lnss_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_op,
    input  logic [7:0]       s_data_byte,
    input  logic             s_select_level,
    input  logic [2:0]       s_bit_index,
    input  logic             s_bit_level,
    input  lnss_pkg::queue_status_t q_status,
    output logic             q_push,
    output lnss_pkg::cmd_t   q_push_cmd
);
    import lnss_pkg::*;

    op_t op;

    assign op      = op_t'(s_op);
    assign s_ready = !q_status.full;

    // drop the unused op code here: it yields no image
    assign q_push = s_valid && s_ready && (op != OP_NONE);

    always_comb begin
        q_push_cmd.kind         = op;
        q_push_cmd.data         = s_data_byte;
        q_push_cmd.select_level = s_select_level;
        q_push_cmd.bit_index    = s_bit_index;
        q_push_cmd.bit_level    = s_bit_level;
        case (op)
            OP_BYTE:    q_push_cmd.start_step = SELECT_POS_STEP;
            OP_NIBBLE:  q_push_cmd.start_step = LOW_NIBBLE_STEP;
            OP_SET_BIT: q_push_cmd.start_step = LAST_STEP;
            default:    q_push_cmd.start_step = LAST_STEP;
        endcase
    end

endmodule

>>> design/lnss_queue.sv
module lnss_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  lnss_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output lnss_pkg::cmd_t          head_cmd,
    output lnss_pkg::queue_status_t status
);
    import lnss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] EMPTY_CNT = '0;

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == EMPTY_CNT);
    assign head_cmd     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/lnss_back.sv
module lnss_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lnss_pkg::cfg_t          cfg,
    input  lnss_pkg::queue_status_t q_status,
    input  lnss_pkg::cmd_t          head_cmd,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_latched_image,
    output logic [9:0]              m_hold_us,
    output logic                    m_last,
    output lnss_pkg::back_status_t  status
);
    import lnss_pkg::*;

    logic               busy_reg, busy_next;
    logic [POS_W-1:0]   step_reg, step_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IMAGE_W-1:0] image_reg, image_next;
    logic               m_valid_reg, m_valid_next;
    logic [IMAGE_W-1:0] m_image_reg, m_image_next;
    logic [HOLD_W-1:0]  m_hold_reg, m_hold_next;
    logic               m_last_reg, m_last_next;

    logic               advance;
    logic               step_last;
    logic [IMAGE_W-1:0] step_image;
    logic [HOLD_W-1:0]  step_hold;
    logic [3:0]         nibble;
    logic [POS_W-1:0]   phase_wide;
    logic [1:0]         phase;
    logic [2:0]         strobe_bit;
    logic [2:0]         select_bit;

    assign strobe_bit = {1'b0, cfg.strobe_pos};
    assign select_bit = {1'b0, cfg.select_pos};

    // advance one image whenever the output register is free or draining
    assign advance = busy_reg && (!m_valid_reg || m_ready);

    assign nibble     = (step_reg >= LOW_NIBBLE_STEP) ? cmd_reg.data[3:0] : cmd_reg.data[7:4];
    assign phase_wide = step_reg - ((step_reg >= LOW_NIBBLE_STEP) ? LOW_NIBBLE_STEP
                                                                 : HIGH_NIBBLE_STEP);
    assign phase      = phase_wide[1:0];

    always_comb begin
        step_image = image_reg;
        step_hold  = NO_WAIT;
        step_last  = (step_reg == LAST_STEP);
        if (cmd_reg.kind == OP_SET_BIT) begin
            step_image = put_bit(image_reg, cmd_reg.bit_index, cmd_reg.bit_level);
            step_last  = 1'b1;
        end else if (step_reg == SELECT_POS_STEP) begin
            step_image = put_bit(image_reg, select_bit, cmd_reg.select_level);
        end else begin
            case (phase)
                PHASE_NIBBLE: begin
                    step_image = (image_reg & LOW_NIBBLE_MASK)
                               | ({nibble, 4'b0000} & HIGH_NIBBLE_MASK);
                end
                PHASE_STROBE_LOW: begin
                    step_image = put_bit(image_reg, strobe_bit, 1'b0);
                    step_hold  = cfg.pulse_wait;
                end
                PHASE_STROBE_HIGH: begin
                    step_image = put_bit(image_reg, strobe_bit, 1'b1);
                    step_hold  = cfg.pulse_wait;
                end
                PHASE_SETTLE: begin
                    step_image = put_bit(image_reg, strobe_bit, 1'b0);
                    step_hold  = cfg.settle_wait;
                end
                default: begin
                    step_image = image_reg;
                end
            endcase
        end
    end

    // take the next request when idle or as the current one finishes, so no cycle is lost between them
    assign q_pop = !q_status.empty && (!busy_reg || (advance && step_last));

    always_comb begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        cmd_next     = cmd_reg;
        image_next   = image_reg;
        m_valid_next = m_valid_reg;
        m_image_next = m_image_reg;
        m_hold_next  = m_hold_reg;
        m_last_next  = m_last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            image_next   = step_image;
            m_valid_next = 1'b1;
            m_image_next = step_image;
            m_hold_next  = step_hold;
            m_last_next  = step_last;
            step_next    = step_reg + 1'b1;
            if (step_last) begin
                busy_next = 1'b0;
            end
        end
        if (q_pop) begin
            busy_next = 1'b1;
            cmd_next  = head_cmd;
            step_next = head_cmd.start_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            image_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            image_reg   <= image_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        m_image_reg <= m_image_next;
        m_hold_reg  <= m_hold_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_latched_image = m_image_reg;
    assign m_hold_us       = m_hold_reg;
    assign m_last          = m_last_reg;
    assign status.busy     = busy_reg;
    assign status.step     = step_reg;

endmodule

>>> tb/sv/tb_lcd_nibble_shift_sequencer.sv
module tb_lcd_nibble_shift_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import lnss_pkg::*;

    localparam int CLK_HIGH_NS     = 4;
    localparam int CLK_LOW_NS      = 4;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_COUNT     = 4;
    localparam int PHASE_REQUESTS  = 42;
    localparam int PRESSURE_BYTES  = 10;
    localparam int MAX_SHOWN       = 10;
    localparam int TIMEOUT_NS      = 2_000_000;

    typedef struct {
        logic [IMAGE_W-1:0] image;
        logic [HOLD_W-1:0]  hold;
        logic               last;
    } lcd_image_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_op;
    logic [7:0] s_data_byte;
    logic       s_select_level;
    logic [2:0] s_bit_index;
    logic       s_bit_level;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_latched_image;
    logic [9:0] m_hold_us;
    logic       m_last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;

    // shadow copy of the block's image and registers
    logic [IMAGE_W-1:0] model_image;
    logic [1:0]         model_sel_pos;
    logic [1:0]         model_strobe_pos;
    logic [HOLD_W-1:0]  model_pulse_wait;
    logic [HOLD_W-1:0]  model_settle_wait;

    lcd_image_t exp_images[$];

    int err_count;
    int images_seen;
    int requests_sent;
    int settings_used;
    int op_count[4];

    bit tx_steady;
    bit rx_steady;
    int rx_hold_req;

    lcd_nibble_shift_sequencer u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_data_byte     (s_data_byte),
        .s_select_level  (s_select_level),
        .s_bit_index     (s_bit_index),
        .s_bit_level     (s_bit_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_latched_image (m_latched_image),
        .m_hold_us       (m_hold_us),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #(CLK_HIGH_NS);
        aclk = 1'b0;
        #(CLK_LOW_NS);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(10, 40);
    endfunction

    function automatic logic [HOLD_W-1:0] pick_wait();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return HOLD_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic void note_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_SHOWN) $display("mismatch: %s", msg);
    endfunction

    function automatic void set_image_bit(logic [2:0] pos, logic level);
        model_image[pos] = level;
    endfunction

    function automatic void push_image(logic [HOLD_W-1:0] hold, logic last);
        lcd_image_t e;
        e.image = model_image;
        e.hold  = hold;
        e.last  = last;
        exp_images.push_back(e);
    endfunction

    // nibble image, then enable low, high, low
    function automatic void queue_nibble(logic [3:0] nib, logic is_last);
        model_image = (model_image & LOW_NIBBLE_MASK) | {nib, 4'h0};
        push_image('0, 1'b0);
        set_image_bit({1'b0, model_strobe_pos}, 1'b0);
        push_image(model_pulse_wait, 1'b0);
        set_image_bit({1'b0, model_strobe_pos}, 1'b1);
        push_image(model_pulse_wait, 1'b0);
        set_image_bit({1'b0, model_strobe_pos}, 1'b0);
        push_image(model_settle_wait, is_last);
    endfunction

    function automatic void predict_images(op_t op, logic [7:0] data, logic sel,
                                           logic [2:0] idx, logic lvl);
        case (op)
            OP_BYTE: begin
                set_image_bit({1'b0, model_sel_pos}, sel);
                push_image('0, 1'b0);
                queue_nibble(data[7:4], 1'b0);
                queue_nibble(data[3:0], 1'b1);
            end
            OP_NIBBLE: begin
                queue_nibble(data[3:0], 1'b1);
            end
            OP_SET_BIT: begin
                set_image_bit(idx, lvl);
                push_image('0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // receiver: random stalls, steady stretches, and a long counted hold-off
    initial begin : rx_proc
        int stall_left;
        int hold_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
                m_ready <= 1'b0;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
                m_ready <= 1'b1;
            end else if (rx_steady) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : image_check
        lcd_image_t want;
        if (aresetn && m_valid && m_ready) begin
            images_seen++;
            if (exp_images.size() == 0) begin
                note_mismatch($sformatf("unexpected image %02h hold %0d last %0b",
                                        m_latched_image, m_hold_us, m_last));
            end else begin
                want = exp_images.pop_front();
                if (m_latched_image !== want.image)
                    note_mismatch($sformatf("image %0d latched_image expected %02h got %02h",
                                            images_seen, want.image, m_latched_image));
                if (m_hold_us !== want.hold)
                    note_mismatch($sformatf("image %0d hold_us expected %0d got %0d",
                                            images_seen, want.hold, m_hold_us));
                if (m_last !== want.last)
                    note_mismatch($sformatf("image %0d last expected %0b got %0b",
                                            images_seen, want.last, m_last));
            end
        end
    end

    task automatic send_request(op_t op, logic [7:0] data, logic sel,
                                logic [2:0] idx, logic lvl);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_data_byte    <= data;
        s_select_level <= sel;
        s_bit_index    <= idx;
        s_bit_level    <= lvl;
        do @(posedge aclk); while (!s_ready);
        predict_images(op, data, sel, idx, lvl);
        requests_sent++;
        op_count[op]++;
    endtask

    task automatic send_random_request(bit bytes_only);
        op_t op;
        int r;
        r = $urandom_range(0, 99);
        if (bytes_only || r < 40) op = OP_BYTE;
        else if (r < 65) op = OP_NIBBLE;
        else if (r < 92) op = OP_SET_BIT;
        else op = OP_NONE;
        send_request(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    // hold the data lines until the block takes the write
    task automatic write_reg(reg_index_t idx, logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SELECT_POS:  model_sel_pos     = val[1:0];
            REG_STROBE_POS:  model_strobe_pos  = val[1:0];
            REG_PULSE_WAIT:  model_pulse_wait  = val;
            REG_SETTLE_WAIT: model_settle_wait = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] sel_pos, logic [1:0] strobe_pos,
                              logic [HOLD_W-1:0] pulse, logic [HOLD_W-1:0] settle);
        write_reg(REG_SELECT_POS, {8'h00, sel_pos});
        write_reg(REG_STROBE_POS, {8'h00, strobe_pos});
        write_reg(REG_PULSE_WAIT, pulse);
        write_reg(REG_SETTLE_WAIT, settle);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // drop the request, wait for every expected image, then let the block settle
    task automatic wait_idle();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (exp_images.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        foreach (exp_images[i])
            note_mismatch($sformatf("missing image %02h hold %0d last %0b",
                                    exp_images[i].image, exp_images[i].hold,
                                    exp_images[i].last));
        exp_images.delete();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_request(OP_BYTE, 8'h00, 1'b0, 3'd0, 1'b0);
        send_request(OP_BYTE, 8'hFF, 1'b1, 3'd7, 1'b1);
        // upper nibble must be ignored by a nibble send
        send_request(OP_NIBBLE, 8'hA5, 1'b1, 3'd7, 1'b1);
        send_request(OP_NIBBLE, 8'hF0, 1'b0, 3'd0, 1'b0);
        send_request(OP_SET_BIT, 8'hFF, 1'b1, 3'd0, 1'b1);
        send_request(OP_SET_BIT, 8'h00, 1'b0, 3'd7, 1'b1);
        send_request(OP_SET_BIT, 8'h00, 1'b0, 3'd7, 1'b0);
        send_request(OP_SET_BIT, 8'h00, 1'b0, 3'd3, 1'b1);
        // unused op: nothing comes out, image stays
        send_request(OP_NONE, 8'hFF, 1'b1, 3'd7, 1'b1);
        send_request(OP_NONE, 8'h00, 1'b0, 3'd0, 1'b0);
        send_request(OP_BYTE, 8'h5A, 1'b1, 3'd5, 1'b1);
        wait_idle();
    endtask

    task automatic test_shared_position();
        set_config(2'd0, 2'd0, '0, '0);
        send_request(OP_BYTE, 8'hC3, 1'b1, 3'd0, 1'b0);
        send_request(OP_NIBBLE, 8'h07, 1'b0, 3'd0, 1'b0);
        wait_idle();
        set_config(2'd3, 2'd3, '1, '1);
        send_request(OP_BYTE, 8'h3C, 1'b0, 3'd0, 1'b0);
        send_request(OP_BYTE, 8'hFF, 1'b1, 3'd0, 1'b0);
        send_request(OP_SET_BIT, 8'h00, 1'b0, 3'd1, 1'b0);
        wait_idle();
        set_config(2'd1, 2'd2, 10'd1, 10'd100);
        send_request(OP_BYTE, 8'h96, 1'b1, 3'd0, 1'b0);
        wait_idle();
    endtask

    task automatic test_back_pressure();
        rx_hold_req = HOLD_OFF_CYCLES;
        tx_steady = 1'b1;
        repeat (PRESSURE_BYTES) send_random_request(1'b1);
        tx_steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       pick_wait(), pick_wait());
            tx_steady = (phase == 2);
            rx_steady = (phase == 2);
            repeat (PHASE_REQUESTS) send_random_request(1'b0);
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            wait_idle();
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL lcd_nibble_shift_sequencer");
        $finish;
    end

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_op           <= OP_NONE;
        s_data_byte    <= '0;
        s_select_level <= 1'b0;
        s_bit_index    <= '0;
        s_bit_level    <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_SELECT_POS;
        cfg_data       <= '0;
        err_count      = 0;
        images_seen    = 0;
        requests_sent  = 0;
        settings_used  = 1;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        rx_hold_req    = 0;
        foreach (op_count[i]) op_count[i] = 0;
        model_image       = '0;
        model_sel_pos     = SELECT_POS_RESET;
        model_strobe_pos  = STROBE_POS_RESET;
        model_pulse_wait  = PULSE_WAIT_RESET;
        model_settle_wait = SETTLE_WAIT_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_shared_position();
        test_back_pressure();
        test_random_phases();
        wait_idle();

        $display("run covered %0d requests (%0d byte, %0d nibble, %0d bit set, %0d unused op)",
                 requests_sent, op_count[OP_BYTE], op_count[OP_NIBBLE],
                 op_count[OP_SET_BIT], op_count[OP_NONE]);
        $display("%0d images checked over %0d register settings, %0d-cycle receiver hold-off",
                 images_seen, settings_used, HOLD_OFF_CYCLES);
        if (err_count == 0) begin
            $display("PASS lcd_nibble_shift_sequencer");
        end else begin
            $display("%0d mismatches", err_count);
            $display("FAIL lcd_nibble_shift_sequencer");
        end
        $finish;
    end

endmodule
